FILE: rtl/mep_pkg.sv
package mep_pkg;

    // widths fixed by the register map
    localparam int SIZE_BITS  = 13;
    localparam int COORD_DEF  = 32;
    localparam int DIM_DEF    = 12;
    localparam int ITER_DEF   = 10;

    // configuration register indexes
    localparam logic [2:0] CFG_REAL_MIN = 3'd0;
    localparam logic [2:0] CFG_REAL_MAX = 3'd1;
    localparam logic [2:0] CFG_IMAG_MIN = 3'd2;
    localparam logic [2:0] CFG_IMAG_MAX = 3'd3;
    localparam logic [2:0] CFG_ITER_LIM = 3'd4;
    localparam logic [2:0] CFG_WIDTH    = 3'd5;
    localparam logic [2:0] CFG_HEIGHT   = 3'd6;
    localparam logic [2:0] CFG_PAL_SEL  = 3'd7;

    // what a division in the divider chain is for
    typedef enum logic [2:0] {
        TAG_X, TAG_Y, TAG_PER, TAG_SEC, TAG_R, TAG_G, TAG_B
    } div_tag_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MAP_MUL, S_ISSUE_X, S_ISSUE_Y, S_MAP_WAIT, S_MUL, S_ADD,
        S_PER_ISSUE, S_PER_WAIT, S_SEC_ISSUE, S_SEC_WAIT, S_CH_ISSUE, S_CH_WAIT,
        S_DONE
    } state_t;

    // palette entries as {red, green, blue}
    function automatic logic [23:0] pal_rgb(input logic sel, input logic [2:0] idx);
        logic [23:0] v;
        case ({sel, idx})
            4'b0_000: v = 24'h000000;
            4'b0_001: v = 24'hD5431F;
            4'b0_010: v = 24'hFBFF79;
            4'b0_011: v = 24'h3EDF59;
            4'b0_100: v = 24'h2B1EDA;
            4'b0_101: v = 24'h00FFF7;
            4'b1_000: v = 24'h000764;
            4'b1_001: v = 24'h206BCB;
            4'b1_010: v = 24'hEDFFFF;
            4'b1_011: v = 24'hFFAA00;
            4'b1_100: v = 24'h000200;
            default:  v = 24'h000000;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pal_chan(input logic sel, input logic [2:0] idx,
                                            input logic [1:0] ch);
        logic [23:0] v;
        logic [7:0]  c;
        v = pal_rgb(sel, idx);
        case (ch)
            2'd0:    c = v[23:16];
            2'd1:    c = v[15:8];
            default: c = v[7:0];
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/mep_div_cell.sv
module mep_div_cell #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 13
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  mep_pkg::div_tag_t    in_tag,
    input  logic [NUM_W-1:0]     in_work,
    input  logic [DEN_W-1:0]     in_rem,
    input  logic [DEN_W-1:0]     in_den,
    output logic                 out_valid,
    output mep_pkg::div_tag_t    out_tag,
    output logic [NUM_W-1:0]     out_work,
    output logic [DEN_W-1:0]     out_rem,
    output logic [DEN_W-1:0]     out_den
);

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             qbit;
    logic             valid_reg;
    mep_pkg::div_tag_t tag_reg;
    logic [NUM_W-1:0] work_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    // one restoring step: bring in the next dividend bit, try to subtract
    always_comb begin
        trial = {in_rem, in_work[NUM_W-1]};
        diff  = trial - {1'b0, in_den};
        qbit  = (trial >= {1'b0, in_den});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg  <= in_tag;
        den_reg  <= in_den;
        work_reg <= {in_work[NUM_W-2:0], qbit};
        rem_reg  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_work  = work_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;

endmodule

FILE: rtl/mep_div_chain.sv
module mep_div_chain #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 13
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  mep_pkg::div_tag_t    in_tag,
    input  logic [NUM_W-1:0]     in_num,
    input  logic [DEN_W-1:0]     in_den,
    output logic                 out_valid,
    output mep_pkg::div_tag_t    out_tag,
    output logic [NUM_W-1:0]     out_quo,
    output logic [DEN_W-1:0]     out_rem
);

    logic              vld [NUM_W+1];
    mep_pkg::div_tag_t tag [NUM_W+1];
    logic [NUM_W-1:0]  work [NUM_W+1];
    logic [DEN_W-1:0]  rem [NUM_W+1];
    logic [DEN_W-1:0]  den [NUM_W+1];

    assign vld[0]  = in_valid;
    assign tag[0]  = in_tag;
    assign work[0] = in_num;
    assign rem[0]  = '0;
    assign den[0]  = in_den;

    // one cell per quotient bit, a new division may enter every cycle
    for (genvar i = 0; i < NUM_W; i++) begin : g_cell
        mep_div_cell #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[i]),
            .in_tag    (tag[i]),
            .in_work   (work[i]),
            .in_rem    (rem[i]),
            .in_den    (den[i]),
            .out_valid (vld[i+1]),
            .out_tag   (tag[i+1]),
            .out_work  (work[i+1]),
            .out_rem   (rem[i+1]),
            .out_den   (den[i+1])
        );
    end

    assign out_valid = vld[NUM_W];
    assign out_tag   = tag[NUM_W];
    assign out_quo   = work[NUM_W];
    assign out_rem   = rem[NUM_W];

endmodule

FILE: rtl/mandelbrot_escape_palette_pixel_top.sv
// channel   | direction | handshake             | payload
// s_        | in        | s_valid / s_ready     | s_pixel_x, s_pixel_y
// m_        | out       | m_valid / m_ready     | m_red, m_green, m_blue, m_escape_count,
//           |           |                       | m_inside_set
// cfg_      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one pixel at a time; divider chain of NUM_W = max(C+DIM_BITS+1, I+9) cells, 45 at defaults
// escaping pixel: the window mapping, the palette section and the three color channels each pass
// through the divider chain, and each escape step takes the states S_MUL and S_ADD
// pixel inside the set: window mapping and escape steps only; zero limit: window mapping only
// reset is synchronous, active low; no clearing pass; cfg_ready is always high
// a finished pixel waits in the output register while the next one is taken in
module mandelbrot_escape_palette_pixel_top #(
    parameter int COORD_BITS = mep_pkg::COORD_DEF,
    parameter int DIM_BITS   = mep_pkg::DIM_DEF,
    parameter int ITER_BITS  = mep_pkg::ITER_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DIM_BITS-1:0]   s_pixel_x,
    input  logic [DIM_BITS-1:0]   s_pixel_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_red,
    output logic [7:0]            m_green,
    output logic [7:0]            m_blue,
    output logic [ITER_BITS-1:0]  m_escape_count,
    output logic                  m_inside_set,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    localparam int C     = COORD_BITS;
    localparam int F     = COORD_BITS - 4;
    localparam int I     = ITER_BITS;
    localparam int SW    = mep_pkg::SIZE_BITS;
    localparam int NUM_W = (C + 1 + DIM_BITS > 9 + I) ? C + 1 + DIM_BITS : 9 + I;
    localparam int DEN_W = (SW > I) ? SW : I;

    localparam logic signed [C-1:0] RMIN_RST = {4'b1110, {F{1'b0}}};
    localparam logic signed [C-1:0] ONE_POS  = {4'b0001, {F{1'b0}}};
    localparam logic signed [C-1:0] ONE_NEG  = {4'b1111, {F{1'b0}}};
    localparam logic [NUM_W-1:0]    OFF_CAP  = {{(NUM_W-C-2){1'b0}}, 1'b1, {(C+1){1'b0}}};
    localparam logic [C+4:0]        ESC_LIM  = {6'b000000, 1'b1, {(C-2){1'b0}}};
    localparam logic signed [C+7:0] SAT_HI   = {9'b0_0000_0000, {(C-1){1'b1}}};
    localparam logic signed [C+7:0] SAT_LO   = {9'b1_1111_1111, {(C-1){1'b0}}};

    function automatic logic signed [C-1:0] sat_c(input logic signed [C+7:0] v);
        logic signed [C-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[C-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[C-1:0];
        end else begin
            r = v[C-1:0];
        end
        return r;
    endfunction

    // configuration registers
    logic signed [C-1:0] real_min_reg, real_max_reg, imag_min_reg, imag_max_reg;
    logic [I-1:0]        limit_reg;
    logic [SW-1:0]       width_reg, height_reg;
    logic                sel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_min_reg <= RMIN_RST;
            real_max_reg <= ONE_POS;
            imag_min_reg <= ONE_NEG;
            imag_max_reg <= ONE_POS;
            limit_reg    <= I'(100);
            width_reg    <= SW'(800);
            height_reg   <= SW'(600);
            sel_reg      <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                mep_pkg::CFG_REAL_MIN: real_min_reg <= cfg_data;
                mep_pkg::CFG_REAL_MAX: real_max_reg <= cfg_data;
                mep_pkg::CFG_IMAG_MIN: imag_min_reg <= cfg_data;
                mep_pkg::CFG_IMAG_MAX: imag_max_reg <= cfg_data;
                mep_pkg::CFG_ITER_LIM: limit_reg    <= cfg_data[I-1:0];
                mep_pkg::CFG_WIDTH:    width_reg    <= cfg_data[SW-1:0];
                mep_pkg::CFG_HEIGHT:   height_reg   <= cfg_data[SW-1:0];
                mep_pkg::CFG_PAL_SEL:  sel_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // state and datapath registers
    mep_pkg::state_t state_reg, state_next;
    logic [DIM_BITS-1:0] px_reg, py_reg;
    logic [NUM_W-1:0]    prodx_reg, prody_reg;
    logic                negx_reg, negy_reg;
    logic signed [C-1:0] cx_reg, cy_reg, a_reg, b_reg;
    logic [C+3:0]        aa_reg, bb_reg;
    logic [C+4:0]        ab_reg;
    logic                sab_reg;
    logic                first_reg;
    logic [I-1:0]        it_reg;
    logic                inside_reg;
    logic [I-1:0]        per_reg, r_reg;
    logic [2:0]          sec_reg;
    logic [1:0]          ch_reg;
    logic [7:0]          red_reg, green_reg, blue_reg;
    logic                m_valid_reg;
    logic [7:0]          m_red_reg, m_green_reg, m_blue_reg;
    logic [I-1:0]        m_count_reg;
    logic                m_inside_reg;

    // divider chain
    logic              div_in_valid;
    mep_pkg::div_tag_t div_in_tag;
    logic [NUM_W-1:0]  div_in_num;
    logic [DEN_W-1:0]  div_in_den;
    logic              div_out_valid;
    mep_pkg::div_tag_t div_out_tag;
    logic [NUM_W-1:0]  div_out_quo;
    logic [DEN_W-1:0]  div_out_rem;

    mep_div_chain #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_in_valid),
        .in_tag    (div_in_tag),
        .in_num    (div_in_num),
        .in_den    (div_in_den),
        .out_valid (div_out_valid),
        .out_tag   (div_out_tag),
        .out_quo   (div_out_quo),
        .out_rem   (div_out_rem)
    );

    // window mapping terms
    logic signed [C:0]  spanx, spany;
    logic [C:0]         magx, magy;
    logic [DEN_W-1:0]   denx, deny;
    logic [NUM_W-1:0]   off_cl;
    logic signed [C+7:0] map_sum;

    function automatic logic signed [C+7:0] cx_reg_src_x();
        return {{8{real_min_reg[C-1]}}, real_min_reg};
    endfunction

    function automatic logic signed [C+7:0] cx_reg_src_y();
        return {{8{imag_min_reg[C-1]}}, imag_min_reg};
    endfunction

    always_comb begin
        spanx = {real_max_reg[C-1], real_max_reg} - {real_min_reg[C-1], real_min_reg};
        spany = {imag_max_reg[C-1], imag_max_reg} - {imag_min_reg[C-1], imag_min_reg};
        magx  = spanx[C] ? -spanx : spanx;
        magy  = spany[C] ? -spany : spany;
        denx  = (width_reg == '0)  ? DEN_W'(1) : DEN_W'(width_reg);
        deny  = (height_reg == '0) ? DEN_W'(1) : DEN_W'(height_reg);
        off_cl = (div_out_quo > OFF_CAP) ? OFF_CAP : div_out_quo;
        if (div_out_tag == mep_pkg::TAG_X) begin
            map_sum = negx_reg ? (C+8)'(cx_reg_src_x()) - (C+8)'(off_cl[C+1:0])
                               : (C+8)'(cx_reg_src_x()) + (C+8)'(off_cl[C+1:0]);
        end else begin
            map_sum = negy_reg ? (C+8)'(cx_reg_src_y()) - (C+8)'(off_cl[C+1:0])
                               : (C+8)'(cx_reg_src_y()) + (C+8)'(off_cl[C+1:0]);
        end
    end

    // escape step terms
    logic [C-1:0]        ma, mb;
    logic [2*C-1:0]      pa, pb, pab;
    logic [C+4:0]        sq_sum;
    logic                escaped;
    logic signed [C+7:0] na_wide, nb_wide, abs_ext;
    logic [I-1:0]        it_inc;

    always_comb begin
        ma = a_reg[C-1] ? C'(-a_reg) : C'(a_reg);
        mb = b_reg[C-1] ? C'(-b_reg) : C'(b_reg);
        pa  = {{C{1'b0}}, ma} * {{C{1'b0}}, ma};
        pb  = {{C{1'b0}}, mb} * {{C{1'b0}}, mb};
        pab = {{C{1'b0}}, ma} * {{C{1'b0}}, mb};
        sq_sum  = {1'b0, aa_reg} + {1'b0, bb_reg};
        escaped = (sq_sum > ESC_LIM);
        abs_ext = {3'b000, ab_reg};
        na_wide = {4'b0000, aa_reg} - {4'b0000, bb_reg} + {{8{cx_reg[C-1]}}, cx_reg};
        nb_wide = (sab_reg ? -abs_ext : abs_ext) + {{8{cy_reg[C-1]}}, cy_reg};
        it_inc  = it_reg + I'(1);
    end

    // palette terms
    logic [2:0]         last_sec;
    logic [NUM_W-1:0]   per_q;
    logic [7:0]         c_lo, c_hi;
    logic [8+I:0]       ch_num;
    mep_pkg::div_tag_t  ch_tag;

    always_comb begin
        last_sec = sel_reg ? 3'd3 : 3'd4;
        per_q    = div_out_quo;
        c_lo     = mep_pkg::pal_chan(sel_reg, sec_reg, ch_reg);
        c_hi     = mep_pkg::pal_chan(sel_reg, sec_reg + 3'd1, ch_reg);
        ch_num   = (9+I)'(c_lo * (per_reg - r_reg)) + (9+I)'(c_hi * r_reg);
        case (ch_reg)
            2'd0:    ch_tag = mep_pkg::TAG_R;
            2'd1:    ch_tag = mep_pkg::TAG_G;
            default: ch_tag = mep_pkg::TAG_B;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mep_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and divider requests
    always_comb begin
        state_next   = state_reg;
        div_in_valid = 1'b0;
        div_in_tag   = mep_pkg::TAG_X;
        div_in_num   = prodx_reg;
        div_in_den   = denx;
        case (state_reg)
            mep_pkg::S_IDLE: begin
                if (s_valid) state_next = mep_pkg::S_MAP_MUL;
            end
            mep_pkg::S_MAP_MUL: state_next = mep_pkg::S_ISSUE_X;
            mep_pkg::S_ISSUE_X: begin
                div_in_valid = 1'b1;
                state_next   = mep_pkg::S_ISSUE_Y;
            end
            mep_pkg::S_ISSUE_Y: begin
                div_in_valid = 1'b1;
                div_in_tag   = mep_pkg::TAG_Y;
                div_in_num   = prody_reg;
                div_in_den   = deny;
                state_next   = mep_pkg::S_MAP_WAIT;
            end
            mep_pkg::S_MAP_WAIT: begin
                if (div_out_valid && div_out_tag == mep_pkg::TAG_Y) begin
                    state_next = (limit_reg == '0) ? mep_pkg::S_DONE : mep_pkg::S_MUL;
                end
            end
            mep_pkg::S_MUL: state_next = mep_pkg::S_ADD;
            mep_pkg::S_ADD: begin
                if (!first_reg && escaped) begin
                    state_next = mep_pkg::S_PER_ISSUE;
                end else if (!first_reg && it_inc == limit_reg) begin
                    state_next = mep_pkg::S_DONE;
                end else begin
                    state_next = mep_pkg::S_MUL;
                end
            end
            mep_pkg::S_PER_ISSUE: begin
                div_in_valid = 1'b1;
                div_in_tag   = mep_pkg::TAG_PER;
                div_in_num   = NUM_W'(limit_reg);
                div_in_den   = sel_reg ? DEN_W'(4) : DEN_W'(5);
                state_next   = mep_pkg::S_PER_WAIT;
            end
            mep_pkg::S_PER_WAIT: begin
                if (div_out_valid && div_out_tag == mep_pkg::TAG_PER) begin
                    state_next = mep_pkg::S_SEC_ISSUE;
                end
            end
            mep_pkg::S_SEC_ISSUE: begin
                div_in_valid = 1'b1;
                div_in_tag   = mep_pkg::TAG_SEC;
                div_in_num   = NUM_W'(it_reg);
                div_in_den   = DEN_W'(per_reg);
                state_next   = mep_pkg::S_SEC_WAIT;
            end
            mep_pkg::S_SEC_WAIT: begin
                if (div_out_valid && div_out_tag == mep_pkg::TAG_SEC) begin
                    state_next = mep_pkg::S_CH_ISSUE;
                end
            end
            mep_pkg::S_CH_ISSUE: begin
                div_in_valid = 1'b1;
                div_in_tag   = ch_tag;
                div_in_num   = NUM_W'(ch_num);
                div_in_den   = DEN_W'(per_reg);
                if (ch_reg == 2'd2) state_next = mep_pkg::S_CH_WAIT;
            end
            mep_pkg::S_CH_WAIT: begin
                if (div_out_valid && div_out_tag == mep_pkg::TAG_B) begin
                    state_next = mep_pkg::S_DONE;
                end
            end
            mep_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) state_next = mep_pkg::S_IDLE;
            end
            default: state_next = mep_pkg::S_IDLE;
        endcase
    end

    // per-pixel datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            mep_pkg::S_IDLE: begin
                px_reg <= s_pixel_x;
                py_reg <= s_pixel_y;
            end
            mep_pkg::S_MAP_MUL: begin
                prodx_reg <= NUM_W'(magx * px_reg);
                prody_reg <= NUM_W'(magy * py_reg);
                negx_reg  <= spanx[C];
                negy_reg  <= spany[C];
                a_reg      <= '0;
                b_reg      <= '0;
                it_reg     <= '0;
                first_reg  <= 1'b1;
                inside_reg <= 1'b1;
                ch_reg     <= 2'd0;
            end
            mep_pkg::S_MUL: begin
                aa_reg  <= pa[2*C-1:F];
                bb_reg  <= pb[2*C-1:F];
                ab_reg  <= pab[2*C-1:F-1];
                sab_reg <= a_reg[C-1] ^ b_reg[C-1];
            end
            mep_pkg::S_ADD: begin
                if (!first_reg && escaped) begin
                    inside_reg <= 1'b0;
                end else begin
                    if (!first_reg) it_reg <= it_inc;
                    a_reg     <= sat_c(na_wide);
                    b_reg     <= sat_c(nb_wide);
                    first_reg <= 1'b0;
                end
            end
            mep_pkg::S_CH_ISSUE: ch_reg <= ch_reg + 2'd1;
            default: ;
        endcase

        // collect divider results by tag
        if (div_out_valid) begin
            case (div_out_tag)
                mep_pkg::TAG_X:   cx_reg <= sat_c(map_sum);
                mep_pkg::TAG_Y:   cy_reg <= sat_c(map_sum);
                mep_pkg::TAG_PER: per_reg <= (per_q == '0) ? I'(1) : per_q[I-1:0];
                mep_pkg::TAG_SEC: begin
                    sec_reg <= (div_out_quo > NUM_W'(last_sec)) ? last_sec
                                                                 : div_out_quo[2:0];
                    r_reg   <= div_out_rem[I-1:0];
                end
                mep_pkg::TAG_R:   red_reg   <= div_out_quo[7:0];
                mep_pkg::TAG_G:   green_reg <= div_out_quo[7:0];
                mep_pkg::TAG_B:   blue_reg  <= div_out_quo[7:0];
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == mep_pkg::S_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == mep_pkg::S_DONE && (!m_valid_reg || m_ready)) begin
            m_red_reg    <= inside_reg ? 8'd0 : red_reg;
            m_green_reg  <= inside_reg ? 8'd0 : green_reg;
            m_blue_reg   <= inside_reg ? 8'd0 : blue_reg;
            m_count_reg  <= (limit_reg == '0) ? '0 : (inside_reg ? limit_reg : it_reg);
            m_inside_reg <= inside_reg;
        end
    end

    assign s_ready        = (state_reg == mep_pkg::S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_red          = m_red_reg;
    assign m_green        = m_green_reg;
    assign m_blue         = m_blue_reg;
    assign m_escape_count = m_count_reg;
    assign m_inside_set   = m_inside_reg;

endmodule

FILE: bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC      = 28;
    localparam longint ESC_BOUND = longint'(2 * 2) <<< FRAC;
    localparam int  WATCHDOG  = 40000;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
    } pixel_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] count;
        logic       in_set;
    } color_t;

    // palette entries {red, green, blue}, red palette first
    localparam bit [7:0] PALETTE [2][6][3] = '{
        '{'{0, 0, 0}, '{213, 67, 31}, '{251, 255, 121}, '{62, 223, 89},
          '{43, 30, 218}, '{0, 255, 247}},
        '{'{0, 7, 100}, '{32, 107, 203}, '{237, 255, 255}, '{255, 170, 0},
          '{0, 2, 0}, '{0, 0, 0}}
    };

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [11:0] s_pixel_x = '0;
    logic [11:0] s_pixel_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_red, m_green, m_blue;
    logic [9:0]  m_escape_count;
    logic        m_inside_set;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    mandelbrot_escape_palette_pixel_top dut (.*);

    // window and palette settings as the block should hold them
    longint      re_lo, re_hi, im_lo, im_hi;
    int unsigned iter_lim, img_w, img_h;
    bit          pal_sel;

    pixel_t      pixel_q[$];
    color_t      color_q[$];
    int          in_flight = 0;
    int          errors = 0;
    int          cfg_count = 0;
    bit          quiet = 1'b0;
    logic        s_took = 1'b0;
    logic        m_took = 1'b0;
    int          s_gap = 0;
    int          m_gap = 0;
    int          idle_cycles = 0;

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // signed fixed-point product, magnitude truncated
    function automatic longint fx_mul(longint p, longint q, int sh);
        longint unsigned mp, mq, m;
        bit neg;
        neg = (p < 0) != (q < 0);
        mp = (p < 0) ? -p : p;
        mq = (q < 0) ? -q : q;
        m = (mp * mq) >> sh;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // pixel index to window coordinate
    function automatic longint map_axis(longint lo, longint hi, longint unsigned pos,
                                        int unsigned size);
        longint span;
        longint unsigned mag, den, qt, rm, off, cap;
        span = hi - lo;
        mag = (span < 0) ? -span : span;
        den = (size != 0) ? size : 1;
        qt = mag / den;
        rm = mag % den;
        cap = 64'd1 << 33;
        if (pos != 0 && qt > cap / pos) off = cap;
        else off = qt * pos + (rm * pos) / den;
        if (off > cap) off = cap;
        return clamp32((span < 0) ? lo - longint'(off) : lo + longint'(off));
    endfunction

    function automatic color_t shade_pixel(logic [11:0] px, logic [11:0] py);
        longint cx, cy, a, b, aa, bb, ab2;
        int unsigned it, per, sec, rr, n;
        color_t res;
        cx = map_axis(re_lo, re_hi, px, img_w);
        cy = map_axis(im_lo, im_hi, py, img_h);
        a = 0;
        b = 0;
        it = 0;
        while (it < iter_lim) begin
            aa = fx_mul(a, a, FRAC);
            bb = fx_mul(b, b, FRAC);
            ab2 = fx_mul(a, b, FRAC - 1);
            a = clamp32(aa - bb + cx);
            b = clamp32(ab2 + cy);
            if (fx_mul(a, a, FRAC) + fx_mul(b, b, FRAC) > ESC_BOUND) break;
            it++;
        end
        res.count = it[9:0];
        if (it >= iter_lim) begin
            res.red = '0;
            res.green = '0;
            res.blue = '0;
            res.in_set = 1'b1;
        end else begin
            n = pal_sel ? 5 : 6;
            per = iter_lim / (n - 1);
            if (per == 0) per = 1;
            sec = it / per;
            if (sec > n - 2) sec = n - 2;
            rr = it % per;
            res.red   = 8'((PALETTE[pal_sel][sec][0] * (per - rr)
                            + PALETTE[pal_sel][sec + 1][0] * rr) / per);
            res.green = 8'((PALETTE[pal_sel][sec][1] * (per - rr)
                            + PALETTE[pal_sel][sec + 1][1] * rr) / per);
            res.blue  = 8'((PALETTE[pal_sel][sec][2] * (per - rr)
                            + PALETTE[pal_sel][sec + 1][2] * rr) / per);
            res.in_set = 1'b0;
        end
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int draw_gap();
        if (quiet || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    // settings at reset
    initial begin
        re_lo = -64'sd536870912;
        re_hi = 64'sd268435456;
        im_lo = -64'sd268435456;
        im_hi = 64'sd268435456;
        iter_lim = 100;
        img_w = 800;
        img_h = 600;
        pal_sel = 1'b0;
    end

    // monitor: transfers on all three channels
    always @(posedge aclk) begin
        color_t want;
        s_took <= s_valid && s_ready;
        m_took <= m_valid && m_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mep_pkg::CFG_REAL_MIN: re_lo = longint'($signed(cfg_data));
                    mep_pkg::CFG_REAL_MAX: re_hi = longint'($signed(cfg_data));
                    mep_pkg::CFG_IMAG_MIN: im_lo = longint'($signed(cfg_data));
                    mep_pkg::CFG_IMAG_MAX: im_hi = longint'($signed(cfg_data));
                    mep_pkg::CFG_ITER_LIM: iter_lim = 32'(cfg_data[9:0]);
                    mep_pkg::CFG_WIDTH:    img_w = 32'(cfg_data[12:0]);
                    mep_pkg::CFG_HEIGHT:   img_h = 32'(cfg_data[12:0]);
                    mep_pkg::CFG_PAL_SEL:  pal_sel = cfg_data[0];
                    default: ;
                endcase
                cfg_count++;
            end
            if (s_valid && s_ready)
                color_q.push_back(shade_pixel(s_pixel_x, s_pixel_y));
            if (m_valid && m_ready) begin
                if (color_q.size() == 0) begin
                    $display("unexpected pixel result at %0t", $realtime);
                    errors++;
                end else begin
                    want = color_q.pop_front();
                    in_flight--;
                    if (m_red !== want.red) report("red", m_red, want.red);
                    if (m_green !== want.green) report("green", m_green, want.green);
                    if (m_blue !== want.blue) report("blue", m_blue, want.blue);
                    if (m_escape_count !== want.count)
                        report("escape_count", m_escape_count, want.count);
                    if (m_inside_set !== want.in_set)
                        report("inside_set", m_inside_set, want.in_set);
                end
            end
        end
    end

    // pixel driver
    always @(negedge aclk) begin
        pixel_t p;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_took) begin
            s_valid <= 1'b1;
        end else if (s_gap > 0) begin
            s_valid <= 1'b0;
            s_gap--;
        end else if (pixel_q.size() != 0) begin
            p = pixel_q.pop_front();
            s_valid <= 1'b1;
            s_pixel_x <= p.x;
            s_pixel_y <= p.y;
            s_gap = draw_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (m_took) m_gap = draw_gap();
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_gap > 0) begin
            m_ready <= 1'b0;
            m_gap--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL mandelbrot_escape_palette_pixel_top");
            $finish;
        end
    end

    task automatic push_pixel(int x, int y);
        pixel_t p;
        p.x = 12'(x);
        p.y = 12'(y);
        pixel_q.push_back(p);
        in_flight++;
    endtask

    task automatic drain();
        while (in_flight != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        int seen;
        @(negedge aclk);
        seen = cfg_count;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge aclk); while (cfg_count == seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(logic [31:0] rl, logic [31:0] rh, logic [31:0] il,
                           logic [31:0] ih, int lim, int w, int h, int sel);
        cfg_write(mep_pkg::CFG_REAL_MIN, rl);
        cfg_write(mep_pkg::CFG_REAL_MAX, rh);
        cfg_write(mep_pkg::CFG_IMAG_MIN, il);
        cfg_write(mep_pkg::CFG_IMAG_MAX, ih);
        cfg_write(mep_pkg::CFG_ITER_LIM, lim);
        cfg_write(mep_pkg::CFG_WIDTH, w);
        cfg_write(mep_pkg::CFG_HEIGHT, h);
        cfg_write(mep_pkg::CFG_PAL_SEL, sel);
    endtask

    // random window around a center, sometimes reversed or arbitrary
    task automatic random_phase(int count, int lim);
        int w, h, c_re, c_im, hw, sel;
        logic [31:0] rl, rh, il, ih;
        c_re = $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
        c_im = $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
        hw = $urandom_range(32'h0010_0000, 32'h2000_0000);
        rl = c_re - hw;
        rh = c_re + hw;
        il = c_im - hw;
        ih = c_im + hw;
        if ($urandom_range(0, 5) == 0) {rl, rh} = {rh, rl};
        if ($urandom_range(0, 7) == 0) begin
            rl = $urandom();
            ih = $urandom();
        end
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 64);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 64);
        sel = $urandom_range(0, 1);
        set_all(rl, rh, il, ih, lim, w, h, sel);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0)
                push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                push_pixel($urandom_range(0, (w > 0 && w <= 4096) ? w - 1 : 4095),
                           $urandom_range(0, (h > 0 && h <= 4096) ? h - 1 : 4095));
        end
        drain();
    endtask

    initial begin
        int lim;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset window: corners, center, alternating bits
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(799, 599);
        push_pixel(400, 300);
        push_pixel(12'hAAA, 12'h555);
        push_pixel(12'h555, 12'hAAA);
        drain();

        // zero limit, then limits too small for a full palette section
        set_all(32'hE000_0000, 32'h1000_0000, 32'hF000_0000, 32'h1000_0000, 0, 800, 600, 0);
        push_pixel(0, 0);
        drain();
        for (int l = 1; l <= 3; l++) begin
            cfg_write(mep_pkg::CFG_ITER_LIM, l);
            push_pixel(0, 0);
            push_pixel(600, 300);
            drain();
        end

        // standard palette, zero image size
        set_all(32'hE000_0000, 32'h1000_0000, 32'hF000_0000, 32'h1000_0000, 40, 0, 0, 1);
        push_pixel(0, 0);
        push_pixel(1, 1);
        push_pixel(4095, 4095);
        drain();

        // extreme window and maximum image size
        set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 10, 8191, 8191, 0);
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(2048, 100);
        drain();

        // largest limit with a point deep inside
        set_all(32'hE000_0000, 32'h1000_0000, 32'hF000_0000, 32'h1000_0000, 1023, 800, 600, 1);
        push_pixel(400, 300);
        push_pixel(0, 0);
        drain();

        // random phases, one of them with the largest limit
        for (int ph = 0; ph < 13; ph++) begin
            quiet = (ph % 3 == 0);
            if (ph == 6) begin
                random_phase(10, 1023);
            end else begin
                lim = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4)
                                                  : $urandom_range(5, 90);
                random_phase(50, lim);
            end
        end

        repeat (300) @(posedge aclk);
        if (errors == 0 && color_q.size() == 0 && in_flight == 0)
            $display("PASS mandelbrot_escape_palette_pixel_top");
        else
            $display("FAIL mandelbrot_escape_palette_pixel_top");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/mep_pkg.sv
rtl/mep_div_cell.sv
rtl/mep_div_chain.sv
rtl/mandelbrot_escape_palette_pixel_top.sv
bench/tb.sv
